@@ hw/rtl/trackball_motion_rotate_conditioner_macros.svh @@
// Assertion macros for the trackball motion conditioner checker.
`ifndef TRACKBALL_MOTION_ROTATE_CONDITIONER_MACROS_SVH
`define TRACKBALL_MOTION_ROTATE_CONDITIONER_MACROS_SVH

// Same-cycle implication, off while reset is high.
`define TMRC_ASSERT_IMPLY(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("tmrc implication check failed");

// Next-cycle implication, off while reset is high.
`define TMRC_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("tmrc next-cycle check failed");

// Property checked at every edge, reset included.
`define TMRC_ASSERT_ALWAYS(label, cond) \
   label: assert property (@(posedge clock) (cond)) \
      else $error("tmrc invariant check failed");

`endif

@@ hw/rtl/tmrc_pkg.sv @@
// Package: payload types, register codes and arithmetic helpers of the motion conditioner.
`timescale 1ns / 1ps
`default_nettype none

package tmrc_pkg;

   localparam int ACC_W     = 26;
   localparam int FRAC_BITS = 14;

   typedef struct packed {
      logic [7:0]        sensor_id;
      logic [7:0]        motion_status;
      logic signed [7:0] raw_x;
      logic signed [7:0] raw_y;
      logic              scroll_mode;
   } req_type;

   typedef struct packed {
      logic              configure_request;
      logic [2:0]        configure_resolution;
      logic              sensor_ready;
      logic [1:0]        report_kind;
      logic signed [7:0] pointer_x;
      logic signed [7:0] pointer_y;
      logic signed [7:0] wheel_h;
      logic signed [7:0] wheel_v;
   } rsp_type;

   typedef struct packed {
      logic enable;
      logic accumulate;
      logic subtract;
   } mac_op_type;

   localparam logic [1:0] CSR_COSINE     = 2'd0;
   localparam logic [1:0] CSR_SINE       = 2'd1;
   localparam logic [1:0] CSR_RESOLUTION = 2'd2;

   localparam logic [1:0] KIND_NONE    = 2'd0;
   localparam logic [1:0] KIND_POINTER = 2'd1;
   localparam logic [1:0] KIND_SCROLL  = 2'd2;
   localparam logic [1:0] KIND_SKIP    = 2'd3;

   localparam logic signed [15:0] COSINE_RESET = 16'sd16384;
   localparam logic [7:0]         READY_ID     = 8'h30;
   localparam int                 MOTION_BIT   = 7;
   localparam logic [5:0]         CHECK_LAST   = 6'd49;
   localparam logic [2:0]         SCROLL_LAST  = 3'd4;
   localparam logic [2:0]         MAX_RES      = 3'd5;

   localparam logic signed [ACC_W-1:0] SLOW_LIMIT_SQ = ACC_W'(400);
   localparam logic signed [ACC_W-1:0] ROUND_BIAS    = ACC_W'((1 << FRAC_BITS) - 1);
   localparam logic signed [ACC_W-1:0] SAT_MAX       = ACC_W'(127);
   localparam logic signed [ACC_W-1:0] SAT_MIN       = -ACC_W'(128);

   // Q12.14 sum to 8 bits: truncate toward zero, then saturate.
   function automatic logic signed [7:0] scale_sat(input logic signed [ACC_W-1:0] acc);
      logic signed [ACC_W-1:0] biased;
      logic signed [ACC_W-1:0] q;
      biased = acc[ACC_W-1] ? acc + ROUND_BIAS : acc;
      q = biased >>> FRAC_BITS;
      if (q > SAT_MAX) begin
         q = SAT_MAX;
      end else if (q < SAT_MIN) begin
         q = SAT_MIN;
      end
      return q[7:0];
   endfunction

   // Halve, rounding away from zero.
   function automatic logic signed [7:0] halve_away(input logic signed [7:0] v);
      logic signed [8:0] w;
      w = v;
      if (v < 0) begin
         w = w >>> 1;
      end else begin
         w = (w + 9'sd1) >>> 1;
      end
      return w[7:0];
   endfunction

endpackage

`default_nettype wire

@@ hw/rtl/trackball_motion_rotate_conditioner.sv @@
// Top level: sequencer, state and output register of the trackball motion conditioner.
//
//  channel  ports                                     role
//  req      req_valid, req_ready, req_data            scan tick in, one transaction per tick
//  rsp      rsp_valid, rsp_ready, rsp_data            one result per tick, registered
//  csr      csr_we, csr_index, csr_wdata              register write, no wait, no read-back
//
// A tick with motion on a ready sensor steps through accept, six passes through the
// shared 8x16 multiplier (two rotated axes, two squares) and one result state.
// A tick without motion skips the passes. req_ready is high only while the sequencer idles.
// Reset is synchronous and needs no clearing pass; the result cycle holds while the
// output register is still full and rsp_ready is low.
`timescale 1ns / 1ps
`default_nettype none

module trackball_motion_rotate_conditioner
   import tmrc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire req_type     req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output rsp_type          rsp_data,
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_wdata
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_XC   = 3'd1;
   localparam logic [2:0] ST_YS   = 3'd2;
   localparam logic [2:0] ST_XS   = 3'd3;
   localparam logic [2:0] ST_YC   = 3'd4;
   localparam logic [2:0] ST_SQX  = 3'd5;
   localparam logic [2:0] ST_SQY  = 3'd6;
   localparam logic [2:0] ST_FIN  = 3'd7;

   logic [2:0]         state_ff, state_in;
   logic [5:0]         phase_ff, phase_in;
   logic [2:0]         sub_ff, sub_in;
   logic               ready_ff, ready_in;
   logic [7:0]         last_id_ff, last_id_in;
   logic signed [15:0] cos_ff, cos_in;
   logic signed [15:0] sin_ff, sin_in;
   logic [2:0]         res_ff, res_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;

   logic               cfg_req_ff, cfg_req_in;
   logic [2:0]         cfg_res_ff, cfg_res_in;
   logic               motion_ff, motion_in;
   logic               scroll_ff, scroll_in;
   logic               cadence_ff, cadence_in;
   logic signed [7:0]  x_ff, x_in;
   logic signed [7:0]  y_ff, y_in;
   logic signed [7:0]  ox_ff, ox_in;
   logic signed [7:0]  oy_ff, oy_in;

   mac_op_type              mac_op;
   logic signed [7:0]       mac_a;
   logic signed [15:0]      mac_b;
   logic signed [ACC_W-1:0] mac_acc;

   logic              accept;
   logic              check;
   logic              id_ok;
   logic              slow;
   logic signed [7:0] fx, fy;

   tmrc_mac u_mac (
      .clock (clock),
      .op    (mac_op),
      .a     (mac_a),
      .b     (mac_b),
      .acc   (mac_acc)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign check     = (phase_ff == '0);
   assign id_ok     = (req_data.sensor_id == READY_ID);
   assign slow      = (mac_acc < SLOW_LIMIT_SQ);
   assign fx        = slow ? halve_away(ox_ff) : ox_ff;
   assign fy        = slow ? halve_away(oy_ff) : oy_ff;

   // operand selection for the shared unit
   always_comb begin
      mac_op = '0;
      mac_a  = x_ff;
      mac_b  = cos_ff;
      unique case (state_ff)
         ST_XC: begin
            mac_op.enable = 1'b1;
         end
         ST_YS: begin
            mac_op = '{enable: 1'b1, accumulate: 1'b1, subtract: 1'b1};
            mac_a  = y_ff;
            mac_b  = sin_ff;
         end
         ST_XS: begin
            mac_op.enable = 1'b1;
            mac_b         = sin_ff;
         end
         ST_YC: begin
            mac_op = '{enable: 1'b1, accumulate: 1'b1, subtract: 1'b0};
            mac_a  = y_ff;
         end
         ST_SQX: begin
            mac_op.enable = 1'b1;
            mac_a         = ox_ff;
            mac_b         = 16'(ox_ff);
         end
         ST_SQY: begin
            mac_op = '{enable: 1'b1, accumulate: 1'b1, subtract: 1'b0};
            mac_a  = oy_ff;
            mac_b  = 16'(oy_ff);
         end
         ST_IDLE, ST_FIN: begin
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      sub_in       = sub_ff;
      ready_in     = ready_ff;
      last_id_in   = last_id_ff;
      cos_in       = cos_ff;
      sin_in       = sin_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      cfg_req_in   = cfg_req_ff;
      cfg_res_in   = cfg_res_ff;
      motion_in    = motion_ff;
      scroll_in    = scroll_ff;
      cadence_in   = cadence_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      ox_in        = ox_ff;
      oy_in        = oy_ff;

      if (csr_we) begin
         unique case (csr_index)
            CSR_COSINE:     cos_in = csr_wdata;
            CSR_SINE:       sin_in = csr_wdata;
            CSR_RESOLUTION: res_in = csr_wdata[2:0];
            default: begin
            end
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               phase_in   = (phase_ff == CHECK_LAST) ? '0 : phase_ff + 6'd1;
               sub_in     = (sub_ff == SCROLL_LAST) ? '0 : sub_ff + 3'd1;
               cadence_in = (sub_ff == SCROLL_LAST);
               cfg_req_in = 1'b0;
               cfg_res_in = '0;
               ready_in   = ready_ff;
               if (check && (req_data.sensor_id != last_id_ff)) begin
                  ready_in   = id_ok;
                  last_id_in = req_data.sensor_id;
                  if (id_ok) begin
                     cfg_req_in = 1'b1;
                     cfg_res_in = (res_ff > MAX_RES) ? MAX_RES : res_ff;
                  end
               end
               motion_in = ready_in && req_data.motion_status[MOTION_BIT];
               scroll_in = req_data.scroll_mode;
               x_in      = req_data.raw_y;
               y_in      = -req_data.raw_x;
               state_in  = motion_in ? ST_XC : ST_FIN;
            end
         end
         ST_XC:  state_in = ST_YS;
         ST_YS:  state_in = ST_XS;
         ST_XS: begin
            ox_in    = scale_sat(mac_acc);
            state_in = ST_YC;
         end
         ST_YC:  state_in = ST_SQX;
         ST_SQX: begin
            oy_in    = scale_sat(mac_acc);
            state_in = ST_SQY;
         end
         ST_SQY: state_in = ST_FIN;
         ST_FIN: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_data_in                      = '0;
               rsp_data_in.configure_request    = cfg_req_ff;
               rsp_data_in.configure_resolution = cfg_res_ff;
               rsp_data_in.sensor_ready         = ready_ff;
               rsp_data_in.report_kind          = KIND_NONE;
               if (motion_ff) begin
                  if (!scroll_ff) begin
                     rsp_data_in.report_kind = KIND_POINTER;
                     rsp_data_in.pointer_x   = fx;
                     rsp_data_in.pointer_y   = fy;
                  end else if (cadence_ff) begin
                     rsp_data_in.report_kind = KIND_SCROLL;
                     rsp_data_in.wheel_h     = fx;
                     rsp_data_in.wheel_v     = -fy;
                  end else begin
                     rsp_data_in.report_kind = KIND_SKIP;
                  end
               end
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= '0;
         sub_ff       <= '0;
         ready_ff     <= 1'b0;
         last_id_ff   <= '0;
         cos_ff       <= COSINE_RESET;
         sin_ff       <= '0;
         res_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         sub_ff       <= sub_in;
         ready_ff     <= ready_in;
         last_id_ff   <= last_id_in;
         cos_ff       <= cos_in;
         sin_ff       <= sin_in;
         res_ff       <= res_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      cfg_req_ff  <= cfg_req_in;
      cfg_res_ff  <= cfg_res_in;
      motion_ff   <= motion_in;
      scroll_ff   <= scroll_in;
      cadence_ff  <= cadence_in;
      x_ff        <= x_in;
      y_ff        <= y_in;
      ox_ff       <= ox_in;
      oy_ff       <= oy_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

@@ hw/rtl/tmrc_mac.sv @@
// Shared 8x16 signed multiply-accumulate unit.
`timescale 1ns / 1ps
`default_nettype none

module tmrc_mac
   import tmrc_pkg::*;
(
   input  wire logic                    clock,
   input  wire mac_op_type              op,
   input  wire logic signed [7:0]       a,
   input  wire logic signed [15:0]      b,
   output logic signed [ACC_W-1:0]      acc
);

   logic signed [23:0]      product;
   logic signed [ACC_W-1:0] base;
   logic signed [ACC_W-1:0] acc_in;
   logic signed [ACC_W-1:0] acc_ff;

   always_comb begin
      product = a * b;
      base    = op.accumulate ? acc_ff : '0;
      acc_in  = op.subtract ? base - ACC_W'(product) : base + ACC_W'(product);
   end

   always_ff @(posedge clock) begin
      if (op.enable) begin
         acc_ff <= acc_in;
      end
   end

   assign acc = acc_ff;

endmodule

`default_nettype wire

@@ hw/rtl/tmrc_checker.sv @@
// Port-level checker for the trackball motion conditioner, with its bind.
`timescale 1ns / 1ps
`default_nettype none
`include "trackball_motion_rotate_conditioner_macros.svh"

module tmrc_checker
   import tmrc_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire rsp_type     rsp_data
);

   logic req_accept;
   logic rsp_stall;

   assign req_accept = req_valid && req_ready && !reset;
   assign rsp_stall  = rsp_valid && !rsp_ready && !reset;

   // a stalled transaction keeps its payload
   `TMRC_ASSERT_NEXT(a_rsp_hold, rsp_stall, rsp_valid && $stable(rsp_data))
   // one tick at a time: busy right after an accept
   `TMRC_ASSERT_NEXT(a_busy_after_accept, req_accept, !req_ready)
   // output register empties on reset
   `TMRC_ASSERT_ALWAYS(a_reset_clears, reset || !$past(reset) || !rsp_valid)
   // pointer deltas only on pointer reports
   `TMRC_ASSERT_IMPLY(a_pointer_zero,
      rsp_valid && (rsp_data.report_kind != KIND_POINTER),
      (rsp_data.pointer_x == 8'sd0) && (rsp_data.pointer_y == 8'sd0))

endmodule

bind trackball_motion_rotate_conditioner tmrc_checker u_checker (.*);

`default_nettype wire

@@ verif/tb.sv @@
`timescale 1ns / 1ps
// Testbench for trackball_motion_rotate_conditioner: directed and random scan ticks, scoreboard check.
module tb;
   import tmrc_pkg::*;

   localparam logic [1:0] CSR_SPARE = 2'd3;
   localparam int CHECK_TICKS  = 50;
   localparam int SCROLL_EVERY = 5;
   localparam int Q_ONE        = 16384;
   localparam int SLOW_SQ      = 400;
   localparam int PHASES       = 9;
   localparam int PHASE_TICKS  = 100;

   class motion_scoreboard;
      logic signed [15:0] cosine;
      logic signed [15:0] sine;
      logic [2:0]         resolution;
      int                 scan_phase;
      bit                 ready;
      logic [7:0]         last_id;
      rsp_type            expected_reports[$];
      int                 errors;
      int                 checked;

      function new();
         cosine = COSINE_RESET;
         sine = '0;
         resolution = '0;
         scan_phase = 0;
         ready = 0;
         last_id = '0;
         errors = 0;
         checked = 0;
      endfunction

      function void write_reg(logic [1:0] idx, logic [15:0] v);
         case (idx)
            CSR_COSINE: cosine = v;
            CSR_SINE: sine = v;
            CSR_RESOLUTION: resolution = v[2:0];
            default: ;
         endcase
      endfunction

      static function int sat8(int v);
         if (v > 127) return 127;
         if (v < -128) return -128;
         return v;
      endfunction

      static function int halve_out(int v);
         return (v + (v >= 0 ? 1 : -1)) / 2;
      endfunction

      function void note_tick(req_type t);
         rsp_type e;
         bit      check;
         int      x, y, c, s, ox, oy;
         e = '0;
         check = (scan_phase == 0);
         scan_phase = (scan_phase + 1 >= CHECK_TICKS) ? 0 : scan_phase + 1;
         if (check && t.sensor_id != last_id) begin
            ready = (t.sensor_id == READY_ID);
            last_id = t.sensor_id;
            if (ready) begin
               e.configure_request = 1'b1;
               e.configure_resolution = (resolution > MAX_RES) ? MAX_RES : resolution;
            end
         end
         e.sensor_ready = ready;
         if (ready && t.motion_status[MOTION_BIT]) begin
            c = cosine;
            s = sine;
            x = $signed(t.raw_y);
            y = $signed(t.raw_x);
            y = (y == -128) ? -128 : -y;
            ox = sat8((x * c - y * s) / Q_ONE);
            oy = sat8((x * s + y * c) / Q_ONE);
            if (ox * ox + oy * oy < SLOW_SQ) begin
               ox = halve_out(ox);
               oy = halve_out(oy);
            end
            if (t.scroll_mode) begin
               if (scan_phase % SCROLL_EVERY == 0) begin
                  e.report_kind = KIND_SCROLL;
                  e.wheel_h = 8'(ox);
                  e.wheel_v = 8'(-oy);
               end else begin
                  e.report_kind = KIND_SKIP;
               end
            end else begin
               e.report_kind = KIND_POINTER;
               e.pointer_x = 8'(ox);
               e.pointer_y = 8'(oy);
            end
         end
         expected_reports.push_back(e);
      endfunction

      task report(string msg);
         errors++;
         if (errors <= 40) $display("tb: result %0d: %s", checked, msg);
      endtask

      task cmp(string fld, logic [7:0] got, logic [7:0] want);
         if (got !== want) report($sformatf("%s got %h expected %h", fld, got, want));
      endtask

      task check_result(rsp_type got);
         rsp_type want;
         checked++;
         if (expected_reports.size() == 0) begin
            report("result with no transaction pending");
            return;
         end
         want = expected_reports.pop_front();
         cmp("configure_request", 8'(got.configure_request), 8'(want.configure_request));
         cmp("configure_resolution", 8'(got.configure_resolution),
             8'(want.configure_resolution));
         cmp("sensor_ready", 8'(got.sensor_ready), 8'(want.sensor_ready));
         cmp("report_kind", 8'(got.report_kind), 8'(want.report_kind));
         cmp("pointer_x", got.pointer_x, want.pointer_x);
         cmp("pointer_y", got.pointer_y, want.pointer_y);
         cmp("wheel_h", got.wheel_h, want.wheel_h);
         cmp("wheel_v", got.wheel_v, want.wheel_v);
      endtask
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_data;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [15:0] csr_wdata = '0;

   motion_scoreboard board = new();
   int tick_count = 0;
   bit quiet_sender = 0;

   logic [15:0] cos_table [7] = '{16'h4000, 16'hC000, 16'h0000, 16'h0000,
                                  16'd11585, 16'h7FFF, 16'h8000};
   logic [15:0] sin_table [7] = '{16'h0000, 16'h0000, 16'h4000, 16'hC000,
                                  16'd11585, 16'h8000, 16'h7FFF};

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   trackball_motion_rotate_conditioner DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   task automatic send_tick(req_type t);
      int gap;
      gap = quiet_sender ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= t;
      do @(posedge clock); while (!req_ready);
      board.note_tick(t);
      tick_count++;
   endtask

   task automatic write_reg(logic [1:0] idx, logic [15:0] v);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
      board.write_reg(idx, v);
   endtask

   task automatic program_regs(logic [15:0] cos_v, logic [15:0] sin_v, logic [2:0] res_v);
      write_reg(CSR_COSINE, cos_v);
      write_reg(CSR_SINE, sin_v);
      write_reg(CSR_RESOLUTION, {13'($urandom), res_v});
      write_reg(CSR_SPARE, 16'($urandom));
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // sender stops and waits for every pending result, then lets the block settle
   task automatic drain();
      req_valid <= 1'b0;
      while (board.expected_reports.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   function automatic req_type make_tick(int id, int st, int rx, int ry, bit sc);
      req_type t;
      t.sensor_id = 8'(id);
      t.motion_status = 8'(st);
      t.raw_x = 8'(rx);
      t.raw_y = 8'(ry);
      t.scroll_mode = sc;
      return t;
   endfunction

   function automatic logic [7:0] pick_delta();
      logic [7:0] d;
      case ($urandom_range(0, 3))
         0, 1: d = 8'($urandom);
         2: d = 8'(int'($urandom_range(0, 40)) - 20);
         default: begin
            case ($urandom_range(0, 3))
               0: d = 8'h80;
               1: d = 8'h7F;
               2: d = 8'h81;
               default: d = 8'h00;
            endcase
         end
      endcase
      return d;
   endfunction

   // check ticks mostly carry the ready id, sometimes a new id or the previous one
   function automatic req_type random_tick(bit check, logic [7:0] prev_id);
      req_type t;
      int      r;
      r = $urandom_range(0, 9);
      if (!check) t.sensor_id = 8'($urandom);
      else if (r < 6) t.sensor_id = READY_ID;
      else if (r < 8) t.sensor_id = 8'($urandom);
      else t.sensor_id = prev_id;
      t.motion_status = 8'($urandom);
      t.motion_status[MOTION_BIT] = ($urandom_range(0, 4) != 0);
      t.raw_x = pick_delta();
      t.raw_y = pick_delta();
      t.scroll_mode = ($urandom_range(0, 2) == 0);
      return t;
   endfunction

   initial begin
      req_type     t;
      int          p, i;
      logic [15:0] cv, sv;
      logic [7:0]  last_check_id;
      bit          check;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      program_regs(COSINE_RESET, 16'h0000, 3'd7);
      send_tick(make_tick(READY_ID, 8'h80, 0, 0, 0));
      send_tick(make_tick(8'hFF, 8'h7F, 5, 5, 0));
      send_tick(make_tick(8'h00, 8'hFF, -128, 127, 0));
      send_tick(make_tick(8'hA5, 8'h80, 127, -128, 0));
      send_tick(make_tick(8'h5A, 8'hC0, -128, -128, 1));
      send_tick(make_tick(8'h30, 8'h80, 1, -1, 1));
      send_tick(make_tick(8'h00, 8'h80, 3, 0, 0));
      send_tick(make_tick(8'h00, 8'h81, -1, 1, 0));
      send_tick(make_tick(8'h00, 8'h80, 14, 14, 0));
      send_tick(make_tick(8'h00, 8'h80, 15, 15, 1));
      send_tick(make_tick(8'h00, 8'h80, 20, 0, 0));
      send_tick(make_tick(8'h00, 8'h00, 90, -90, 1));
      send_tick(make_tick(8'h00, 8'h80, 0, -19, 1));
      send_tick(make_tick(8'h00, 8'h80, -127, 0, 1));
      last_check_id = READY_ID;
      drain();
      for (p = 0; p < PHASES; p++) begin
         if (p < 7) begin
            cv = cos_table[p];
            sv = sin_table[p];
         end else if (p == 7) begin
            cv = 16'($urandom);
            sv = 16'($urandom);
         end else begin
            cv = 16'(int'($urandom_range(0, 32768)) - 16384);
            sv = 16'(int'($urandom_range(0, 32768)) - 16384);
         end
         program_regs(cv, sv, 3'(p));
         quiet_sender = (p % 3 == 1);
         for (i = 0; i < PHASE_TICKS; i++) begin
            check = (tick_count % CHECK_TICKS == 0);
            t = random_tick(check, last_check_id);
            if (check) last_check_id = t.sensor_id;
            send_tick(t);
         end
         drain();
      end
      if (board.errors == 0 && board.expected_reports.size() == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end

   // result side; one long hold-off lets the block back up into its input
   initial begin
      int gap;
      bit quiet;
      bit held_off;
      quiet = 0;
      held_off = 0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if ($urandom_range(0, 39) == 0) quiet = !quiet;
         gap = quiet ? 0 : $urandom_range(0, 14);
         if (!held_off && board.checked >= 250) begin
            held_off = 1;
            gap = 300;
         end
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         board.check_result(rsp_data);
      end
   end

   initial begin
      #5000000;
      $display("tb: done, errors");
      $finish;
   end

endmodule

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/tmrc_pkg.sv
hw/rtl/tmrc_mac.sv
hw/rtl/trackball_motion_rotate_conditioner.sv
hw/rtl/tmrc_checker.sv
verif/tb.sv
